@@ hdl/brd_pkg.sv @@
// shared types, codes and field widths for the binary request deframer
package brd_pkg;

    localparam int DataW  = 8;
    localparam int LenW   = 32;
    localparam int KindW  = 2;
    localparam int CmdW   = 2;
    localparam int PhaseW = 3;
    localparam int TdataW = 104;
    localparam int TuserW = 4;

    // command bytes on the wire
    localparam logic [DataW-1:0] CMD_BYTE_PUT   = 8'd11;
    localparam logic [DataW-1:0] CMD_BYTE_DEL   = 8'd12;
    localparam logic [DataW-1:0] CMD_BYTE_GET   = 8'd13;
    localparam logic [DataW-1:0] CMD_BYTE_STATS = 8'd21;

    // command codes carried in results
    localparam logic [CmdW-1:0] CODE_PUT   = 2'd0;
    localparam logic [CmdW-1:0] CODE_DEL   = 2'd1;
    localparam logic [CmdW-1:0] CODE_GET   = 2'd2;
    localparam logic [CmdW-1:0] CODE_STATS = 2'd3;

    // result kinds
    localparam logic [KindW-1:0] KIND_KEY   = 2'd0;
    localparam logic [KindW-1:0] KIND_VALUE = 2'd1;
    localparam logic [KindW-1:0] KIND_DONE  = 2'd2;
    localparam logic [KindW-1:0] KIND_ERROR = 2'd3;

    // parser phases
    localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
    localparam logic [PhaseW-1:0] PH_KEYLEN = 3'd1;
    localparam logic [PhaseW-1:0] PH_KEY    = 3'd2;
    localparam logic [PhaseW-1:0] PH_VALLEN = 3'd3;
    localparam logic [PhaseW-1:0] PH_VALUE  = 3'd4;

    // number of bytes in a length prefix
    localparam logic [LenW-1:0] LEN_BYTES = 32'd4;

    typedef struct packed {
        logic [KindW-1:0] item_kind;
        logic [CmdW-1:0]  command;
        logic [DataW-1:0] payload_byte;
        logic [LenW-1:0]  byte_offset;
        logic [LenW-1:0]  key_length;
        logic [LenW-1:0]  value_length;
        logic             request_end;
    } result_t;

endpackage

@@ hdl/brd_parse.sv @@
// request parser: phase state and per-byte result decode
module brd_parse (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_fire,
    input  logic [brd_pkg::DataW-1:0] data_byte,
    output logic                      res_valid,
    output brd_pkg::result_t          res
);

    logic [brd_pkg::PhaseW-1:0] phase_reg, phase_next;
    logic [brd_pkg::CmdW-1:0]   cmd_reg, cmd_next;
    logic [brd_pkg::LenW-1:0]   count_reg, count_next;
    logic [brd_pkg::LenW-1:0]   klen_reg, klen_next;
    logic [brd_pkg::LenW-1:0]   vlen_reg, vlen_next;

    logic                       is_put;
    logic [brd_pkg::LenW-1:0]   count_inc;
    logic [brd_pkg::LenW-1:0]   klen_shift;
    logic [brd_pkg::LenW-1:0]   vlen_shift;
    logic                       key_last;
    logic                       val_last;

    assign is_put     = (cmd_reg == brd_pkg::CODE_PUT);
    assign count_inc  = count_reg + 32'd1;
    assign klen_shift = {klen_reg[brd_pkg::LenW-9:0], data_byte};
    assign vlen_shift = {vlen_reg[brd_pkg::LenW-9:0], data_byte};
    assign key_last   = (count_reg == klen_reg - 32'd1);
    assign val_last   = (count_reg == vlen_reg - 32'd1);

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        klen_next  = klen_reg;
        vlen_next  = vlen_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.command = cmd_reg;
        case (phase_reg)
            brd_pkg::PH_KEYLEN: begin
                klen_next  = klen_shift;
                count_next = count_inc;
                if (count_inc >= brd_pkg::LEN_BYTES) begin
                    count_next = '0;
                    if (klen_shift != '0) begin
                        phase_next = brd_pkg::PH_KEY;
                    end else if (is_put) begin
                        phase_next = brd_pkg::PH_VALLEN;
                    end else begin
                        phase_next      = brd_pkg::PH_IDLE;
                        res_valid       = 1'b1;
                        res.item_kind   = brd_pkg::KIND_DONE;
                        res.request_end = 1'b1;
                    end
                end
            end
            brd_pkg::PH_KEY: begin
                res_valid        = 1'b1;
                res.item_kind    = brd_pkg::KIND_KEY;
                res.payload_byte = data_byte;
                res.byte_offset  = count_reg;
                res.key_length   = klen_reg;
                res.request_end  = key_last && !is_put;
                if (key_last) begin
                    count_next = '0;
                    phase_next = is_put ? brd_pkg::PH_VALLEN : brd_pkg::PH_IDLE;
                end else begin
                    count_next = count_inc;
                end
            end
            brd_pkg::PH_VALLEN: begin
                vlen_next  = vlen_shift;
                count_next = count_inc;
                if (count_inc >= brd_pkg::LEN_BYTES) begin
                    count_next = '0;
                    if (vlen_shift != '0) begin
                        phase_next = brd_pkg::PH_VALUE;
                    end else begin
                        phase_next      = brd_pkg::PH_IDLE;
                        res_valid       = 1'b1;
                        res.item_kind   = brd_pkg::KIND_DONE;
                        res.key_length  = klen_reg;
                        res.request_end = 1'b1;
                    end
                end
            end
            brd_pkg::PH_VALUE: begin
                res_valid        = 1'b1;
                res.item_kind    = brd_pkg::KIND_VALUE;
                res.payload_byte = data_byte;
                res.byte_offset  = count_reg;
                res.key_length   = klen_reg;
                res.value_length = vlen_reg;
                res.request_end  = val_last;
                if (val_last) begin
                    count_next = '0;
                    phase_next = brd_pkg::PH_IDLE;
                end else begin
                    count_next = count_inc;
                end
            end
            default: begin
                // idle, and any unused phase code, takes the byte as a command
                phase_next = brd_pkg::PH_IDLE;
                count_next = '0;
                klen_next  = '0;
                vlen_next  = '0;
                case (data_byte)
                    brd_pkg::CMD_BYTE_PUT: begin
                        cmd_next   = brd_pkg::CODE_PUT;
                        phase_next = brd_pkg::PH_KEYLEN;
                    end
                    brd_pkg::CMD_BYTE_DEL: begin
                        cmd_next   = brd_pkg::CODE_DEL;
                        phase_next = brd_pkg::PH_KEYLEN;
                    end
                    brd_pkg::CMD_BYTE_GET: begin
                        cmd_next   = brd_pkg::CODE_GET;
                        phase_next = brd_pkg::PH_KEYLEN;
                    end
                    brd_pkg::CMD_BYTE_STATS: begin
                        cmd_next        = brd_pkg::CODE_STATS;
                        res_valid       = 1'b1;
                        res.item_kind   = brd_pkg::KIND_DONE;
                        res.command     = brd_pkg::CODE_STATS;
                        res.request_end = 1'b1;
                    end
                    default: begin
                        cmd_next        = brd_pkg::CODE_PUT;
                        res_valid       = 1'b1;
                        res.item_kind   = brd_pkg::KIND_ERROR;
                        res.command     = brd_pkg::CODE_PUT;
                        res.request_end = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= brd_pkg::PH_IDLE;
            cmd_reg   <= brd_pkg::CODE_PUT;
            count_reg <= '0;
            klen_reg  <= '0;
            vlen_reg  <= '0;
        end else if (byte_fire) begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            klen_reg  <= klen_next;
            vlen_reg  <= vlen_next;
        end
    end

endmodule

@@ hdl/brd_out_reg.sv @@
// result register with skid entry; absorbs one result under back-pressure, then holds off input until it drains
module brd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             in_valid,
    input  brd_pkg::result_t in_res,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output brd_pkg::result_t out_res
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    brd_pkg::result_t main_reg;
    brd_pkg::result_t skid_reg;
    logic             push;

    assign push      = in_fire && in_valid;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (out_ready) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !out_ready) begin
                skid_reg <= in_res;
            end else begin
                main_reg <= in_res;
            end
        end
    end

endmodule

@@ hdl/binary_request_deframer_unit.sv @@
// binary request deframer: one request byte in, at most one tagged result out
// a result is registered in the result register (or its skid entry on a stall) before the master side sees it
// throughput: one byte per cycle while the skid entry is empty; that entry absorbs one result
// while the master side stalls, s_tready drops only once that entry is occupied
// reset: aresetn low at a clock edge empties the result stage and returns the parser
// to idle with all lengths and counts cleared
module binary_request_deframer_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [brd_pkg::DataW-1:0]  s_tdata,   // data_byte[7:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [brd_pkg::TdataW-1:0] m_tdata,   // payload_byte[7:0], byte_offset[39:8],
                                                  // key_length[71:40], value_length[103:72]
    output logic [brd_pkg::TuserW-1:0] m_tuser,   // item_kind[1:0], command[3:2]
    output logic                       m_tlast
);

    logic             byte_fire;
    logic             res_valid;
    brd_pkg::result_t res;
    brd_pkg::result_t out_res;

    assign byte_fire = s_tvalid && s_tready;

    brd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .data_byte (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    brd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (byte_fire),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.value_length, out_res.key_length,
                      out_res.byte_offset, out_res.payload_byte};
    assign m_tuser = {out_res.command, out_res.item_kind};
    assign m_tlast = out_res.request_end;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the binary request deframer unit
`timescale 1ns / 1ps

module testbench;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [brd_pkg::DataW-1:0]  s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [brd_pkg::TdataW-1:0] m_tdata;
    logic [brd_pkg::TuserW-1:0] m_tuser;
    logic                       m_tlast;

    binary_request_deframer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [brd_pkg::DataW-1:0] request_bytes[$];
    brd_pkg::result_t          awaited_results[$];

    // parser state mirrored on the testbench side
    logic [brd_pkg::PhaseW-1:0] parse_phase = brd_pkg::PH_IDLE;
    logic [brd_pkg::CmdW-1:0]   cur_cmd = brd_pkg::CODE_PUT;
    logic [brd_pkg::LenW-1:0]   byte_count = '0;
    logic [brd_pkg::LenW-1:0]   key_len_acc = '0;
    logic [brd_pkg::LenW-1:0]   val_len_acc = '0;

    int  failures = 0;
    int  bytes_driven = 0;
    int  total_bytes = 0;
    int  kind_seen[4] = '{0, 0, 0, 0};
    int  send_idle_pct = 13;
    int  recv_idle_pct = 56;
    bit  taken = 1'b0;
    bit  hold_off = 1'b0;

    function automatic bit deframe_byte(input logic [brd_pkg::DataW-1:0] b,
                                        output brd_pkg::result_t r);
        bit is_put;
        bit last;
        r = '0;
        is_put = (cur_cmd == brd_pkg::CODE_PUT);
        case (parse_phase)
            brd_pkg::PH_KEYLEN: begin
                key_len_acc = {key_len_acc[brd_pkg::LenW-brd_pkg::DataW-1:0], b};
                byte_count++;
                if (byte_count < brd_pkg::LEN_BYTES)
                    return 1'b0;
                byte_count = '0;
                if (key_len_acc != '0) begin
                    parse_phase = brd_pkg::PH_KEY;
                    return 1'b0;
                end
                if (is_put) begin
                    parse_phase = brd_pkg::PH_VALLEN;
                    return 1'b0;
                end
                parse_phase = brd_pkg::PH_IDLE;
                r.item_kind = brd_pkg::KIND_DONE;
                r.command = cur_cmd;
                r.request_end = 1'b1;
                return 1'b1;
            end
            brd_pkg::PH_KEY: begin
                last = (byte_count == key_len_acc - 32'd1);
                r.item_kind = brd_pkg::KIND_KEY;
                r.command = cur_cmd;
                r.payload_byte = b;
                r.byte_offset = byte_count;
                r.key_length = key_len_acc;
                r.request_end = last && !is_put;
                if (last) begin
                    byte_count = '0;
                    parse_phase = is_put ? brd_pkg::PH_VALLEN : brd_pkg::PH_IDLE;
                end else begin
                    byte_count++;
                end
                return 1'b1;
            end
            brd_pkg::PH_VALLEN: begin
                val_len_acc = {val_len_acc[brd_pkg::LenW-brd_pkg::DataW-1:0], b};
                byte_count++;
                if (byte_count < brd_pkg::LEN_BYTES)
                    return 1'b0;
                byte_count = '0;
                if (val_len_acc != '0) begin
                    parse_phase = brd_pkg::PH_VALUE;
                    return 1'b0;
                end
                parse_phase = brd_pkg::PH_IDLE;
                r.item_kind = brd_pkg::KIND_DONE;
                r.command = cur_cmd;
                r.key_length = key_len_acc;
                r.request_end = 1'b1;
                return 1'b1;
            end
            brd_pkg::PH_VALUE: begin
                last = (byte_count == val_len_acc - 32'd1);
                r.item_kind = brd_pkg::KIND_VALUE;
                r.command = cur_cmd;
                r.payload_byte = b;
                r.byte_offset = byte_count;
                r.key_length = key_len_acc;
                r.value_length = val_len_acc;
                r.request_end = last;
                if (last) begin
                    byte_count = '0;
                    parse_phase = brd_pkg::PH_IDLE;
                end else begin
                    byte_count++;
                end
                return 1'b1;
            end
            default: begin
                // any other phase code falls back to command decoding
                parse_phase = brd_pkg::PH_IDLE;
                byte_count = '0;
                key_len_acc = '0;
                val_len_acc = '0;
                if (b == brd_pkg::CMD_BYTE_PUT || b == brd_pkg::CMD_BYTE_DEL
                        || b == brd_pkg::CMD_BYTE_GET) begin
                    cur_cmd = (b == brd_pkg::CMD_BYTE_PUT) ? brd_pkg::CODE_PUT
                            : (b == brd_pkg::CMD_BYTE_DEL) ? brd_pkg::CODE_DEL
                            : brd_pkg::CODE_GET;
                    parse_phase = brd_pkg::PH_KEYLEN;
                    return 1'b0;
                end
                if (b == brd_pkg::CMD_BYTE_STATS) begin
                    cur_cmd = brd_pkg::CODE_STATS;
                    r.item_kind = brd_pkg::KIND_DONE;
                    r.command = brd_pkg::CODE_STATS;
                    r.request_end = 1'b1;
                    return 1'b1;
                end
                cur_cmd = brd_pkg::CODE_PUT;
                r.item_kind = brd_pkg::KIND_ERROR;
                r.request_end = 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic push_len(input logic [brd_pkg::LenW-1:0] len);
        for (int i = 3; i >= 0; i--)
            request_bytes.push_back(len[i*8 +: 8]);
    endtask

    // queue a request: command, key length and random key, then for a put the value length and tail_bytes random bytes
    task automatic push_request(input logic [brd_pkg::DataW-1:0] cmd_byte,
                                input logic [brd_pkg::LenW-1:0] klen,
                                input logic [brd_pkg::LenW-1:0] vlen, input int tail_bytes);
        request_bytes.push_back(cmd_byte);
        if (cmd_byte == brd_pkg::CMD_BYTE_STATS)
            return;
        push_len(klen);
        for (int i = 0; i < klen; i++)
            request_bytes.push_back(8'($urandom_range(255)));
        if (cmd_byte != brd_pkg::CMD_BYTE_PUT)
            return;
        push_len(vlen);
        for (int i = 0; i < tail_bytes; i++)
            request_bytes.push_back(8'($urandom_range(255)));
    endtask

    function automatic logic [brd_pkg::LenW-1:0] random_len();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 90)
            return $urandom_range(8, 1);
        if (r < 98)
            return $urandom_range(40, 9);
        return $urandom_range(300, 200);
    endfunction

    task automatic check_field(input string name, input logic [brd_pkg::LenW-1:0] exp_v,
                               input logic [brd_pkg::LenW-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    // acceptance on the input side feeds the predictor; the monitor checks the output side
    always @(posedge aclk) begin
        brd_pkg::result_t exp_r;
        brd_pkg::result_t act_r;
        if (aresetn && s_tvalid && s_tready) begin
            taken = 1'b1;
            if (deframe_byte(s_tdata, exp_r))
                awaited_results.push_back(exp_r);
        end
        if (aresetn && m_tvalid && m_tready) begin
            act_r.item_kind    = m_tuser[1:0];
            act_r.command      = m_tuser[3:2];
            act_r.payload_byte = m_tdata[7:0];
            act_r.byte_offset  = m_tdata[39:8];
            act_r.key_length   = m_tdata[71:40];
            act_r.value_length = m_tdata[103:72];
            act_r.request_end  = m_tlast;
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing expected: kind %0d", act_r.item_kind);
                failures++;
            end else begin
                exp_r = awaited_results.pop_front();
                check_field("item_kind", 32'(exp_r.item_kind), 32'(act_r.item_kind));
                check_field("command", 32'(exp_r.command), 32'(act_r.command));
                check_field("payload_byte", 32'(exp_r.payload_byte),
                            32'(act_r.payload_byte));
                check_field("byte_offset", exp_r.byte_offset, act_r.byte_offset);
                check_field("key_length", exp_r.key_length, act_r.key_length);
                check_field("value_length", exp_r.value_length, act_r.value_length);
                check_field("request_end", 32'(exp_r.request_end), 32'(act_r.request_end));
            end
            kind_seen[act_r.item_kind]++;
        end
    end

    // driver: new byte offered only once the previous one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (bytes_driven >= 2 * total_bytes / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (bytes_driven >= total_bytes / 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 13;
            end
            if (taken || !s_tvalid) begin
                if (request_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= request_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    bytes_driven++;
                end else begin
                    s_tdata  <= 8'($urandom_range(255));
                    s_tvalid <= 1'b0;
                end
            end
            taken = 1'b0;
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall while the sender keeps going
    initial begin
        wait (total_bytes != 0 && bytes_driven >= 2 * total_bytes / 3 + 100);
        hold_off = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int pick;
        logic [brd_pkg::LenW-1:0] klen;
        logic [brd_pkg::LenW-1:0] vlen;
        logic [brd_pkg::DataW-1:0] noise;

        // directed: stats, unknown commands, empty key and value cases, extreme bytes
        push_request(brd_pkg::CMD_BYTE_STATS, '0, '0, 0);
        request_bytes.push_back(8'h00);
        request_bytes.push_back(8'hff);
        push_request(brd_pkg::CMD_BYTE_DEL, '0, '0, 0);
        push_request(brd_pkg::CMD_BYTE_GET, '0, '0, 0);
        push_request(brd_pkg::CMD_BYTE_PUT, '0, '0, 0);
        request_bytes.push_back(brd_pkg::CMD_BYTE_GET);
        push_len(32'd1);
        request_bytes.push_back(8'hff);

        while (request_bytes.size() < 1720) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // stray byte in idle; avoid opening a request with a random header
                noise = 8'($urandom_range(255));
                if (noise == brd_pkg::CMD_BYTE_PUT || noise == brd_pkg::CMD_BYTE_DEL
                        || noise == brd_pkg::CMD_BYTE_GET)
                    noise = 8'h00;
                request_bytes.push_back(noise);
            end else if (pick < 15) begin
                push_request(brd_pkg::CMD_BYTE_STATS, '0, '0, 0);
            end else begin
                klen = random_len();
                vlen = random_len();
                case ($urandom_range(2))
                    0: push_request(brd_pkg::CMD_BYTE_PUT, klen, vlen, vlen);
                    1: push_request(brd_pkg::CMD_BYTE_DEL, klen, '0, 0);
                    default: push_request(brd_pkg::CMD_BYTE_GET, klen, '0, 0);
                endcase
            end
        end
        // open-ended put with an all-ones value length to reach the top length bits
        push_request(brd_pkg::CMD_BYTE_PUT, 32'd2, 32'hffff_ffff, 20);
        total_bytes = request_bytes.size();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (request_bytes.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d request bytes accepted across three idling mixes and one long stall",
                 bytes_driven);
        $display("results checked: %0d key, %0d value, %0d completion, %0d error",
                 kind_seen[brd_pkg::KIND_KEY], kind_seen[brd_pkg::KIND_VALUE],
                 kind_seen[brd_pkg::KIND_DONE], kind_seen[brd_pkg::KIND_ERROR]);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/brd_pkg.sv
hdl/brd_parse.sv
hdl/brd_out_reg.sv
hdl/binary_request_deframer_unit.sv
sim/testbench.sv
